FILE: rtl/nps_pkg.sv
// Shared types, codes and helpers for the nearest point snap block.
// Used by the queue front end, the scan back end and the top level.
// Depends on nothing.
`default_nettype none

package nps_pkg;

  // Input item kinds as they arrive on the request channel.
  localparam logic [1:0] KIND_NODE   = 2'd0;
  localparam logic [1:0] KIND_MEMBER = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Operations held in the queue after classification.
  localparam logic [1:0] OP_NODE_WR   = 2'd0;
  localparam logic [1:0] OP_MEMBER_WR = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  // Snap result types.
  localparam logic [1:0] SNAP_NONE = 2'd0;
  localparam logic [1:0] SNAP_NODE = 2'd1;
  localparam logic [1:0] SNAP_MID  = 2'd2;
  localparam logic [1:0] SNAP_GRID = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_NODE_EN  = 3'd0;
  localparam logic [2:0] REG_MID_EN   = 3'd1;
  localparam logic [2:0] REG_GRID_EN  = 3'd2;
  localparam logic [2:0] REG_SPACING  = 3'd3;
  localparam logic [2:0] REG_WORK_Z   = 3'd4;

  // Spacings at or below this snap to the query point, unrounded.
  localparam logic [30:0] GRID_TINY_MAX = 31'd6;

  // Reset value of the grid spacing register.
  localparam logic [30:0] SPACING_RESET = 31'd65536;

  // One classified request waiting in the queue.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slot;
    logic        entry_valid;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [30:0] max_dist;
    logic [7:0]  start_slot;
    logic [7:0]  end_slot;
  } item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic        node_en;
    logic        mid_en;
    logic        grid_en;
    logic [30:0] grid_spacing;
    logic [31:0] working_z;
  } cfg_t;

  // Floored half of the sum of two signed coordinates.
  function automatic logic [31:0] floor_mid(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nearest_point_snap.sv
// Nearest point snap: a node and member store with a 3D snap search.
//
// Requests arrive on the item channel (item_valid, item_stall). Kind 0
// writes or removes a node, kind 1 a member, kind 2 is a snap query; any
// other kind is dropped. Writes give no result; each query gives exactly
// one result on the result channel (result_valid, result_stall).
// A two-entry queue sits between the accepting front end and the search
// engine, so requests keep flowing while a result waits to be taken.
// The engine does each write as it pops it from the queue. A query
// scans every node slot if node snapping is on, then every member
// slot if midpoint snapping is on, one slot per cycle through a
// five-stage distance pipeline. When the grid fallback runs it adds
// two 34-step divisions, one cycle per quotient bit. Results are
// delivered one query at a time. Reset empties both tables and
// loads the register defaults. While the receiver stalls, the
// result is held, the engine waits with the next result, and the
// front end stalls once the queue is full. Configuration must be
// written over the APB port only while idle; the block does not
// enforce it. Depends on nps_pkg, nps_front, nps_back and nps_ram.
`default_nettype none

module nearest_point_snap #(
  parameter int NODE_SLOTS   = 256,
  parameter int MEMBER_SLOTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Request channel
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [7:0]         slot,
  input  wire logic               entry_valid,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [30:0]        max_dist,
  input  wire logic [7:0]         start_slot,
  input  wire logic [7:0]         end_slot,
  // Result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    snapped,
  output logic [1:0]              snap_type,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [7:0]              target_slot
);

  nps_pkg::cfg_t  cfg;
  logic           q_valid;
  nps_pkg::item_t q_item;
  logic           q_pop;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_en      <= 1'b1;
      cfg.mid_en       <= 1'b1;
      cfg.grid_en      <= 1'b1;
      cfg.grid_spacing <= nps_pkg::SPACING_RESET;
      cfg.working_z    <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        nps_pkg::REG_NODE_EN: cfg.node_en      <= pwdata[0];
        nps_pkg::REG_MID_EN:  cfg.mid_en       <= pwdata[0];
        nps_pkg::REG_GRID_EN: cfg.grid_en      <= pwdata[0];
        nps_pkg::REG_SPACING: cfg.grid_spacing <= pwdata[30:0];
        nps_pkg::REG_WORK_Z:  cfg.working_z    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      nps_pkg::REG_NODE_EN: prdata = {31'd0, cfg.node_en};
      nps_pkg::REG_MID_EN:  prdata = {31'd0, cfg.mid_en};
      nps_pkg::REG_GRID_EN: prdata = {31'd0, cfg.grid_en};
      nps_pkg::REG_SPACING: prdata = {1'b0, cfg.grid_spacing};
      nps_pkg::REG_WORK_Z:  prdata = cfg.working_z;
      default:              prdata = 32'd0;
    endcase
  end

  nps_front #(
    .NODE_SLOTS   (NODE_SLOTS),
    .MEMBER_SLOTS (MEMBER_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .slot        (slot),
    .entry_valid (entry_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .max_dist    (max_dist),
    .start_slot  (start_slot),
    .end_slot    (end_slot),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  nps_back #(
    .NODE_SLOTS   (NODE_SLOTS),
    .MEMBER_SLOTS (MEMBER_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .snapped      (snapped),
    .snap_type    (snap_type),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .target_slot  (target_slot)
  );

endmodule

`default_nettype wire

FILE: rtl/nps_ram.sv
// Generic single write port RAM with one registered read port.
// Holds the node and member tables. No dependencies.
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/nps_front.sv
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on nps_pkg.
`default_nettype none

module nps_front #(
  parameter int NODE_SLOTS   = 256,
  parameter int MEMBER_SLOTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [7:0]         slot,
  input  wire logic               entry_valid,
  input  wire logic [31:0]        pos_x,
  input  wire logic [31:0]        pos_y,
  input  wire logic [31:0]        pos_z,
  input  wire logic [30:0]        max_dist,
  input  wire logic [7:0]         start_slot,
  input  wire logic [7:0]         end_slot,
  output logic                    q_valid,
  output nps_pkg::item_t          q_item,
  input  wire logic               q_pop
);

  nps_pkg::item_t fifo [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           keep;
  logic           push;
  nps_pkg::item_t cls;

  // Classify: writes beyond the tables and unknown kinds are dropped.
  always_comb begin
    cls.slot        = slot;
    cls.entry_valid = entry_valid;
    cls.pos_x       = pos_x;
    cls.pos_y       = pos_y;
    cls.pos_z       = pos_z;
    cls.max_dist    = max_dist;
    cls.start_slot  = start_slot;
    cls.end_slot    = end_slot;
    cls.op          = nps_pkg::OP_QUERY;
    keep            = 1'b0;
    unique case (kind)
      nps_pkg::KIND_NODE: begin
        cls.op = nps_pkg::OP_NODE_WR;
        keep   = (32'(slot) < NODE_SLOTS);
      end
      nps_pkg::KIND_MEMBER: begin
        cls.op = nps_pkg::OP_MEMBER_WR;
        keep   = (32'(slot) < MEMBER_SLOTS);
      end
      nps_pkg::KIND_QUERY: begin
        cls.op = nps_pkg::OP_QUERY;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_stall = (count == 2'd2);
  assign accept     = item_valid && !item_stall;
  assign push       = accept && keep;
  assign q_valid    = (count != 2'd0);
  assign q_item     = fifo[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nps_back.sv
// Back end: performs table writes and runs the enabled node, midpoint
// and grid searches for each query, then holds the result for the receiver.
// Depends on nps_pkg and nps_ram.
`default_nettype none

module nps_back #(
  parameter int NODE_SLOTS   = 256,
  parameter int MEMBER_SLOTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nps_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire nps_pkg::item_t     q_item,
  output logic                    q_pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    snapped,
  output logic [1:0]              snap_type,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [7:0]              target_slot
);

  localparam int NODE_DEPTH = (NODE_SLOTS > 256) ? 256 : NODE_SLOTS;
  localparam int MEM_DEPTH  = (MEMBER_SLOTS > 256) ? 256 : MEMBER_SLOTS;
  localparam int NW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int MW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [7:0] NODE_LAST = 8'(NODE_DEPTH - 1);
  localparam logic [7:0] MEM_LAST  = 8'(MEM_DEPTH - 1);
  localparam logic [7:0] DIV_LAST  = 8'd33;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_NODE  = 4'd2;
  localparam logic [3:0] ST_MEM   = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_GRID  = 4'd5;
  localparam logic [3:0] ST_GDIV  = 4'd6;
  localparam logic [3:0] ST_GMUL  = 4'd7;
  localparam logic [3:0] ST_GSAT  = 4'd8;
  localparam logic [3:0] ST_GDIST = 4'd9;
  localparam logic [3:0] ST_GWAIT = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0]  state;
  logic [7:0]  cnt;

  // Present bits.
  logic        np [NODE_DEPTH];
  logic        mp [MEM_DEPTH];

  // Latched query.
  logic [31:0] qp_x, qp_y, qp_z;
  logic [30:0] q_md;

  // Best candidate so far.
  logic [63:0] best;
  logic        hit;
  logic [1:0]  btype;
  logic [7:0]  btarget;
  logic [31:0] bx, by, bz;

  // Grid working registers.
  logic        coord;
  logic [33:0] div_n;
  logic [31:0] div_r;
  logic [33:0] div_q;
  logic [62:0] prod;
  logic [61:0] g_sq;
  logic [63:0] grid_lim;
  logic [31:0] gx, gy;

  // Scan pipeline registers.
  logic        s1_v, s1_node;
  logic [7:0]  s1_idx;
  logic        s2_v, s2_node;
  logic [7:0]  s2_idx;
  logic        s3_v;
  logic [1:0]  s3_type;
  logic [7:0]  s3_idx;
  logic [31:0] s3_x, s3_y, s3_z;
  logic        s4_v;
  logic [1:0]  s4_type;
  logic [7:0]  s4_idx;
  logic [31:0] s4_x, s4_y, s4_z;
  logic [31:0] s4_ax, s4_ay, s4_az;
  logic        s5_v;
  logic [1:0]  s5_type;
  logic [7:0]  s5_idx;
  logic [31:0] s5_x, s5_y, s5_z;
  logic [63:0] s5_sx, s5_sy, s5_sz;

  // Memory ports.
  logic        node_we, mem_we;
  logic [95:0] node_a_q, node_b_q;
  logic [15:0] mem_q;
  logic [7:0]  na, nb;
  logic        ok;
  logic        a_ok, b_ok;

  // Combinational helpers.
  logic        iss_v;
  logic        grid_inject;
  logic        pipe_empty;
  logic [31:0] c_x, c_y, c_z;
  logic [32:0] dx, dy, dz;
  logic [65:0] dsum;
  logic [61:0] md_sq;
  logic [32:0] div_rs;
  logic        div_ge;
  logic [31:0] div_d;
  logic [31:0] sat_v;
  logic        sat_neg;
  logic [31:0] mag_x, mag_y;
  logic        tiny;
  logic        out_free;

  assign iss_v       = (state == ST_NODE) || (state == ST_MEM);
  assign grid_inject = (state == ST_GDIST);
  assign pipe_empty  = !(s1_v || s2_v || s3_v || s4_v || s5_v);
  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign node_we     = q_pop && (q_item.op == nps_pkg::OP_NODE_WR) && q_item.entry_valid;
  assign mem_we      = q_pop && (q_item.op == nps_pkg::OP_MEMBER_WR) && q_item.entry_valid;
  assign md_sq       = q_md * q_md;
  assign tiny        = (cfg.grid_spacing <= nps_pkg::GRID_TINY_MAX);
  assign out_free    = !result_valid || !result_stall;

  // Two copies of the node table so a member reads both ends at once.
  nps_ram #(.WIDTH(96), .DEPTH(NODE_DEPTH)) u_node_a (
    .clk   (clk),
    .we    (node_we),
    .waddr (q_item.slot[NW-1:0]),
    .wdata ({q_item.pos_x, q_item.pos_y, q_item.pos_z}),
    .raddr (na[NW-1:0]),
    .rdata (node_a_q)
  );

  nps_ram #(.WIDTH(96), .DEPTH(NODE_DEPTH)) u_node_b (
    .clk   (clk),
    .we    (node_we),
    .waddr (q_item.slot[NW-1:0]),
    .wdata ({q_item.pos_x, q_item.pos_y, q_item.pos_z}),
    .raddr (nb[NW-1:0]),
    .rdata (node_b_q)
  );

  nps_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_member (
    .clk   (clk),
    .we    (mem_we),
    .waddr (q_item.slot[MW-1:0]),
    .wdata ({q_item.start_slot, q_item.end_slot}),
    .raddr (cnt[MW-1:0]),
    .rdata (mem_q)
  );

  // Stage one: pick the node addresses and decide whether the slot counts.
  always_comb begin
    a_ok = (32'(mem_q[15:8]) < NODE_SLOTS);
    b_ok = (32'(mem_q[7:0]) < NODE_SLOTS);
    if (s1_node) begin
      na = s1_idx;
      nb = s1_idx;
      ok = np[s1_idx[NW-1:0]];
    end else begin
      na = mem_q[15:8];
      nb = mem_q[7:0];
      ok = mp[s1_idx[MW-1:0]] && a_ok && b_ok && np[na[NW-1:0]] && np[nb[NW-1:0]];
    end
  end

  // Stage two: candidate point, a node or a member midpoint.
  always_comb begin
    if (s2_node) begin
      c_x = node_a_q[95:64];
      c_y = node_a_q[63:32];
      c_z = node_a_q[31:0];
    end else begin
      c_x = nps_pkg::floor_mid(node_a_q[95:64], node_b_q[95:64]);
      c_y = nps_pkg::floor_mid(node_a_q[63:32], node_b_q[63:32]);
      c_z = nps_pkg::floor_mid(node_a_q[31:0], node_b_q[31:0]);
    end
  end

  // Stage three: signed differences to the query point.
  assign dx = {s3_x[31], s3_x} - {qp_x[31], qp_x};
  assign dy = {s3_y[31], s3_y} - {qp_y[31], qp_y};
  assign dz = {s3_z[31], s3_z} - {qp_z[31], qp_z};

  // Stage five: squared distance.
  assign dsum = 66'(s5_sx) + 66'(s5_sy) + 66'(s5_sz);

  // One restoring division step for the grid rounding.
  assign div_d  = {cfg.grid_spacing, 1'b0};
  assign div_rs = {div_r, div_n[33]};
  assign div_ge = (div_rs >= {1'b0, div_d});

  // Magnitudes of the query coordinates.
  assign mag_x = qp_x[31] ? (32'd0 - qp_x) : qp_x;
  assign mag_y = qp_y[31] ? (32'd0 - qp_y) : qp_y;

  // Saturate the rounded grid coordinate to the 32-bit range.
  always_comb begin
    sat_neg = coord ? qp_y[31] : qp_x[31];
    if (sat_neg) begin
      sat_v = (prod > 63'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - prod[31:0]);
    end else begin
      sat_v = (prod > 63'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
    end
  end

  // Scan pipeline data path.
  always_ff @(posedge clk) begin
    s1_node <= (state == ST_NODE);
    s1_idx  <= cnt;
    s2_node <= s1_node;
    s2_idx  <= s1_idx;
    if (grid_inject) begin
      s3_type <= nps_pkg::SNAP_GRID;
      s3_idx  <= 8'd0;
      s3_x    <= gx;
      s3_y    <= gy;
      s3_z    <= cfg.working_z;
    end else begin
      s3_type <= s2_node ? nps_pkg::SNAP_NODE : nps_pkg::SNAP_MID;
      s3_idx  <= s2_idx;
      s3_x    <= c_x;
      s3_y    <= c_y;
      s3_z    <= c_z;
    end
    s4_type <= s3_type;
    s4_idx  <= s3_idx;
    s4_x    <= s3_x;
    s4_y    <= s3_y;
    s4_z    <= s3_z;
    s4_ax   <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
    s4_ay   <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
    s4_az   <= dz[32] ? 32'(33'd0 - dz) : dz[31:0];
    s5_type <= s4_type;
    s5_idx  <= s4_idx;
    s5_x    <= s4_x;
    s5_y    <= s4_y;
    s5_z    <= s4_z;
    s5_sx   <= s4_ax * s4_ax;
    s5_sy   <= s4_ay * s4_ay;
    s5_sz   <= s4_az * s4_az;
  end

  // Query latch, grid unit and result registers.
  always_ff @(posedge clk) begin
    if (q_pop && (q_item.op == nps_pkg::OP_QUERY)) begin
      qp_x <= q_item.pos_x;
      qp_y <= q_item.pos_y;
      qp_z <= q_item.pos_z;
      q_md <= q_item.max_dist;
    end
    if (state == ST_GRID) begin
      g_sq  <= cfg.grid_spacing * cfg.grid_spacing;
      coord <= 1'b0;
      div_n <= {1'b0, mag_x, 1'b0} + 34'(cfg.grid_spacing);
      div_r <= 32'd0;
      div_q <= 34'd0;
    end
    if (state == ST_GDIV) begin
      div_n <= {div_n[32:0], 1'b0};
      div_q <= {div_q[32:0], div_ge};
      div_r <= div_ge ? 32'(div_rs - {1'b0, div_d}) : div_rs[31:0];
    end
    if (state == ST_GMUL) begin
      prod     <= div_q[31:0] * cfg.grid_spacing;
      grid_lim <= 64'(({2'b00, g_sq} + {1'b0, g_sq, 1'b0}) >> 1);
    end
    if (state == ST_GSAT) begin
      if (!coord) begin
        gx    <= sat_v;
        coord <= 1'b1;
        div_n <= {1'b0, mag_y, 1'b0} + 34'(cfg.grid_spacing);
        div_r <= 32'd0;
        div_q <= 34'd0;
      end else begin
        gy <= sat_v;
      end
    end
    if ((state == ST_OUT) && out_free) begin
      snapped     <= hit;
      snap_type   <= btype;
      out_x       <= bx;
      out_y       <= by;
      out_z       <= bz;
      target_slot <= btarget;
    end
  end

  // Best candidate tracking.
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      best    <= 64'(md_sq);
      hit     <= 1'b0;
      btype   <= nps_pkg::SNAP_NONE;
      btarget <= 8'd0;
      bx      <= qp_x;
      by      <= qp_y;
      bz      <= qp_z;
    end else if ((state == ST_GRID) && !hit && cfg.grid_en && tiny) begin
      hit     <= 1'b1;
      btype   <= nps_pkg::SNAP_GRID;
      btarget <= 8'd0;
    end else if (s5_v) begin
      if (s5_type == nps_pkg::SNAP_GRID) begin
        if (dsum <= 66'(grid_lim)) begin
          hit     <= 1'b1;
          btype   <= nps_pkg::SNAP_GRID;
          btarget <= 8'd0;
          bx      <= s5_x;
          by      <= s5_y;
          bz      <= s5_z;
        end
      end else if (dsum < 66'(best)) begin
        best    <= dsum[63:0];
        hit     <= 1'b1;
        btype   <= s5_type;
        btarget <= s5_idx;
        bx      <= s5_x;
        by      <= s5_y;
        bz      <= s5_z;
      end
    end
  end

  // Control: sequencer, pipeline valids, present bits and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= 8'd0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      s5_v         <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < NODE_DEPTH; i++) begin
        np[i] <= 1'b0;
      end
      for (int i = 0; i < MEM_DEPTH; i++) begin
        mp[i] <= 1'b0;
      end
    end else begin
      s1_v <= iss_v;
      s2_v <= s1_v && ok;
      s3_v <= s2_v || grid_inject;
      s4_v <= s3_v;
      s5_v <= s4_v;
      // A new result is loaded, or the waiting one stays until it is taken.
      result_valid <= ((state == ST_OUT) && out_free) || (result_valid && result_stall);
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_item.op)
              nps_pkg::OP_NODE_WR: begin
                np[q_item.slot[NW-1:0]] <= q_item.entry_valid;
              end
              nps_pkg::OP_MEMBER_WR: begin
                mp[q_item.slot[MW-1:0]] <= q_item.entry_valid;
              end
              nps_pkg::OP_QUERY: begin
                state <= ST_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_INIT: begin
          cnt <= 8'd0;
          if (cfg.node_en) begin
            state <= ST_NODE;
          end else if (cfg.mid_en) begin
            state <= ST_MEM;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_NODE: begin
          if (cnt == NODE_LAST) begin
            cnt   <= 8'd0;
            state <= cfg.mid_en ? ST_MEM : ST_DRAIN;
          end else begin
            cnt <= cnt + 8'd1;
          end
        end
        ST_MEM: begin
          if (cnt == MEM_LAST) begin
            cnt   <= 8'd0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 8'd1;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            state <= ST_GRID;
          end
        end
        ST_GRID: begin
          cnt <= 8'd0;
          if (hit || !cfg.grid_en || tiny) begin
            state <= ST_OUT;
          end else begin
            state <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          if (cnt == DIV_LAST) begin
            cnt   <= 8'd0;
            state <= ST_GMUL;
          end else begin
            cnt <= cnt + 8'd1;
          end
        end
        ST_GMUL: begin
          state <= ST_GSAT;
        end
        ST_GSAT: begin
          state <= coord ? ST_GDIST : ST_GDIV;
        end
        ST_GDIST: begin
          state <= ST_GWAIT;
        end
        ST_GWAIT: begin
          if (pipe_empty) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
